// ===== rtl/rbrd_pkg.sv =====
// Shared types and constants of the run-length bitmap decoder.
package rbrd_pkg;

    // Field widths of the stream words.
    localparam int ADDR_W   = 12;
    localparam int PIX_W    = 8;
    localparam int RUN_W    = 5;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 2;
    localparam int PHASE_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] REG_SCAN_DIR = 1'b0;
    localparam logic [CFG_IW-1:0] REG_COMP     = 1'b1;

    // Decode phase codes; the unused code behaves as PH_TOKEN.
    localparam logic [PHASE_W-1:0] PH_TOKEN  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_VALUE  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_MARKER = 2'd2;

    // Byte codes of the coded stream.
    localparam logic [PIX_W-1:0] RUN_HDR_MASK = 8'hE0;
    localparam logic [PIX_W-1:0] RUN_CNT_MASK = 8'h1F;
    localparam logic [PIX_W-1:0] TRANSPARENT  = 8'hFF;

    // Scan direction codes.
    localparam logic [1:0] DIR_0   = 2'd0;
    localparam logic [1:0] DIR_90  = 2'd1;
    localparam logic [1:0] DIR_180 = 2'd2;
    localparam logic [1:0] DIR_270 = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic run_step;
        logic err_emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic run_start;
        logic run_last;
        logic run_ovf;
    } t_sts;

endpackage

// ===== rtl/rbrd_in_if.sv =====
// Input byte channel of the run-length bitmap decoder.
interface rbrd_in_if;
    import rbrd_pkg::*;

    logic             valid;
    logic             ready;
    logic             frame_start;
    logic [PIX_W-1:0] data_byte;

    modport source (output valid, output frame_start, output data_byte, input ready);
    modport sink   (input valid, input frame_start, input data_byte, output ready);
endinterface

// ===== rtl/rbrd_out_if.sv =====
// Pixel result channel of the run-length bitmap decoder.
interface rbrd_out_if;
    import rbrd_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] pixel_address;
    logic [PIX_W-1:0]  pixel_value;
    logic              write_enable;
    logic              last_of_run;
    logic              frame_done;
    logic              error;

    modport source (
        output valid, output pixel_address, output pixel_value, output write_enable,
        output last_of_run, output frame_done, output error, input ready
    );
    modport sink (
        input valid, input pixel_address, input pixel_value, input write_enable,
        input last_of_run, input frame_done, input error, output ready
    );
endinterface

// ===== rtl/rbrd_ctrl.sv =====
// Controller state machine: byte intake, run emission and error word.
module rbrd_ctrl
    import rbrd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_ERR  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Bytes are taken only in idle, and only when the output register can be refilled.
    assign o_in_ready       = (r_state == S_IDLE) && i_sts.out_free;
    assign o_cmd.accept     = i_in_valid && o_in_ready;
    assign o_cmd.run_step   = (r_state == S_RUN) && i_sts.out_free;
    assign o_cmd.err_emit   = (r_state == S_ERR) && i_sts.out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_sts.run_start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (o_cmd.run_step && i_sts.run_last) begin
                    n_state = i_sts.run_ovf ? S_ERR : S_IDLE;
                end
            end
            S_ERR: begin
                if (o_cmd.err_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    // An overflowing run always ends in the error word.
    a_ovf_to_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && i_sts.out_free && i_sts.run_last && i_sts.run_ovf
        |=> (r_state == S_ERR))
        else $error("overflowing run did not reach the error state");

    // The error state is entered only from a run.
    a_err_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_state != S_ERR))
        else $error("error state entered from idle");

    // Only one datapath command is issued at a time.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.run_step, o_cmd.err_emit}))
        else $error("conflicting datapath commands");
`endif

endmodule

// ===== rtl/rbrd_datapath.sv =====
// Datapath: configuration, scan counters, run registers, placement and output register.
module rbrd_datapath
    import rbrd_pkg::*;
#(
    parameter int SIDE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_frame_start,
    input  logic [PIX_W-1:0]  i_data_byte,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [ADDR_W-1:0] o_pixel_address,
    output logic [PIX_W-1:0]  o_pixel_value,
    output logic              o_write_enable,
    output logic              o_last_of_run,
    output logic              o_frame_done,
    output logic              o_error
);

    localparam int CW   = $clog2(SIDE);
    localparam int AXW  = (2 * CW > ADDR_W) ? 2 * CW : ADDR_W;
    localparam int CMPW = (CW + 1 > RUN_W) ? CW + 1 : RUN_W;
    localparam logic [CW-1:0]  LAST = CW'(SIDE - 1);
    localparam logic [AXW-1:0] SZ   = AXW'(SIDE);

    // Rotated placement of scan column c, scan row r.
    function automatic logic [ADDR_W-1:0] place(
        input logic [CW-1:0] c,
        input logic [CW-1:0] r,
        input logic [1:0]    dir
    );
        logic [CW-1:0]  hi;
        logic [CW-1:0]  lo;
        logic [AXW-1:0] full;
        unique case (dir)
            DIR_0: begin
                hi = r;
                lo = c;
            end
            DIR_90: begin
                hi = LAST - c;
                lo = r;
            end
            DIR_180: begin
                hi = LAST - r;
                lo = LAST - c;
            end
            default: begin
                hi = c;
                lo = LAST - r;
            end
        endcase
        full = AXW'(hi) * SZ + AXW'(lo);
        return full[ADDR_W-1:0];
    endfunction

    // Configuration and decoder state.
    logic [1:0]         r_scan_dir, n_scan_dir;
    logic               r_comp, n_comp;
    logic [CW-1:0]      r_col, n_col;
    logic [CW-1:0]      r_row, n_row;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [RUN_W-1:0]   r_run_len, n_run_len;
    logic               r_halted, n_halted;
    logic [PIX_W-1:0]   r_run_val, n_run_val;
    logic [RUN_W-1:0]   r_left, n_left;
    logic               r_ovf, n_ovf;

    // Output register.
    logic               r_ov, n_ov;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [PIX_W-1:0]   r_val, n_val;
    logic               r_we, n_we;
    logic               r_last, n_last;
    logic               r_done, n_done;
    logic               r_err, n_err;

    // Frame start view of the state, and the pixel position in use.
    logic [CW-1:0]      e_col, e_row, px_col, px_row;
    logic [PHASE_W-1:0] e_phase;
    logic               e_halt;
    logic [PIX_W-1:0]   px_val;
    logic [CMPW-1:0]    rem_x;
    logic               run_ovf_now;
    logic               is_header;
    logic               wrap, frame_end;
    logic               d_emit, d_start;

    assign e_col   = i_frame_start ? '0 : r_col;
    assign e_row   = i_frame_start ? '0 : r_row;
    assign e_phase = i_frame_start ? PH_TOKEN : r_phase;
    assign e_halt  = i_frame_start ? 1'b0 : r_halted;

    assign px_col  = i_cmd.run_step ? r_col : e_col;
    assign px_row  = i_cmd.run_step ? r_row : e_row;
    assign px_val  = i_cmd.run_step ? r_run_val : i_data_byte;

    assign rem_x       = CMPW'(SIDE) - CMPW'(e_col);
    assign run_ovf_now = CMPW'(r_run_len) > rem_x;
    assign is_header   = (i_data_byte & RUN_HDR_MASK) == RUN_HDR_MASK;
    assign wrap        = (px_col == LAST);
    assign frame_end   = wrap && (px_row == LAST);

    // Classify the offered byte: a single pixel now, or the start of a run.
    always_comb begin
        d_emit  = 1'b0;
        d_start = 1'b0;
        if (!e_halt) begin
            if (!r_comp) begin
                d_emit = 1'b1;
            end else if (e_phase == PH_VALUE) begin
                d_start = (r_run_len != '0);
            end else if (e_phase != PH_MARKER) begin
                d_emit = !is_header;
            end
        end
    end

    assign o_sts.out_free  = !r_ov || i_out_ready;
    assign o_sts.run_start = d_start;
    assign o_sts.run_last  = (r_left == RUN_W'(1));
    assign o_sts.run_ovf   = r_ovf;

    // Next state of the decoder and the output register.
    always_comb begin
        n_scan_dir = r_scan_dir;
        n_comp     = r_comp;
        n_col      = r_col;
        n_row      = r_row;
        n_phase    = r_phase;
        n_run_len  = r_run_len;
        n_halted   = r_halted;
        n_run_val  = r_run_val;
        n_left     = r_left;
        n_ovf      = r_ovf;
        n_ov       = i_out_ready ? 1'b0 : r_ov;
        n_addr     = r_addr;
        n_val      = r_val;
        n_we       = r_we;
        n_last     = r_last;
        n_done     = r_done;
        n_err      = r_err;

        if (i_cfg_we) begin
            if (i_cfg_index == REG_SCAN_DIR) begin
                n_scan_dir = i_cfg_data;
            end else begin
                n_comp = i_cfg_data[0];
            end
        end

        // Byte intake.
        if (i_cmd.accept) begin
            if (i_frame_start) begin
                n_col     = '0;
                n_row     = '0;
                n_phase   = PH_TOKEN;
                n_run_len = '0;
                n_halted  = 1'b0;
            end
            if (!e_halt) begin
                n_phase = PH_TOKEN;
                if (r_comp && (e_phase == PH_VALUE)) begin
                    n_run_len = '0;
                    n_run_val = i_data_byte;
                    n_ovf     = run_ovf_now;
                    n_left    = run_ovf_now ? rem_x[RUN_W-1:0] : r_run_len;
                end else if (r_comp && (e_phase != PH_MARKER) && is_header) begin
                    n_run_len = RUN_W'(i_data_byte & RUN_CNT_MASK);
                    n_phase   = PH_VALUE;
                end
            end
        end

        // Pixel emission with scan advance, for a single byte or one run step.
        if ((i_cmd.accept && d_emit) || i_cmd.run_step) begin
            n_ov   = 1'b1;
            n_addr = place(px_col, px_row, r_scan_dir);
            n_val  = px_val;
            n_we   = (px_val != TRANSPARENT);
            n_last = i_cmd.accept || (o_sts.run_last && !r_ovf);
            n_done = 1'b0;
            if (i_cmd.run_step && r_ovf) begin
                // Overflowing run: fill the row out, the frame is dropped anyway.
                n_col  = px_col + CW'(1);
                n_left = r_left - RUN_W'(1);
            end else begin
                if (i_cmd.run_step) begin
                    n_left = r_left - RUN_W'(1);
                end
                if (wrap) begin
                    n_col = '0;
                    if (frame_end) begin
                        n_done   = 1'b1;
                        n_halted = 1'b1;
                    end else begin
                        n_row = px_row + CW'(1);
                        if (r_comp) begin
                            n_phase = PH_MARKER;
                        end
                    end
                end else begin
                    n_col = px_col + CW'(1);
                end
            end
        end

        // Error word after an overflowing run.
        if (i_cmd.err_emit) begin
            n_ov     = 1'b1;
            n_addr   = '0;
            n_val    = '0;
            n_we     = 1'b0;
            n_last   = 1'b1;
            n_done   = 1'b0;
            n_err    = 1'b1;
            n_halted = 1'b1;
        end else if ((i_cmd.accept && d_emit) || i_cmd.run_step) begin
            n_err = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_dir <= DIR_0;
            r_comp     <= 1'b1;
            r_col      <= '0;
            r_row      <= '0;
            r_phase    <= PH_TOKEN;
            r_run_len  <= '0;
            r_halted   <= 1'b1;
            r_left     <= '0;
            r_ovf      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_scan_dir <= n_scan_dir;
            r_comp     <= n_comp;
            r_col      <= n_col;
            r_row      <= n_row;
            r_phase    <= n_phase;
            r_run_len  <= n_run_len;
            r_halted   <= n_halted;
            r_left     <= n_left;
            r_ovf      <= n_ovf;
            r_ov       <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_run_val <= n_run_val;
        r_addr    <= n_addr;
        r_val     <= n_val;
        r_we      <= n_we;
        r_last    <= n_last;
        r_done    <= n_done;
        r_err     <= n_err;
    end

    assign o_out_valid     = r_ov;
    assign o_pixel_address = r_addr;
    assign o_pixel_value   = r_val;
    assign o_write_enable  = r_we;
    assign o_last_of_run   = r_last;
    assign o_frame_done    = r_done;
    assign o_error         = r_err;

`ifndef NO_ASSERTIONS
    // The error word closes its byte, writes nothing and never ends a frame.
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_err |-> !r_we && r_last && !r_done)
        else $error("malformed error word");

    // The error word is issued only for an overflowing run.
    a_err_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.err_emit |-> r_ovf)
        else $error("error word without overflow");

    // After the error word the decoder stays halted until a frame start.
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.err_emit |=> r_halted)
        else $error("decoder not halted after error");
`endif

endmodule

// ===== rtl/rle_bitmap_rotating_decoder.sv =====
// Top level of the run-length bitmap decoder with rotated placement.
// Decodes the pixel bytes of one SIDE x SIDE texture per frame, raw or
// run-length coded, and gives one word per pixel with its rotated address.
// A raw or literal byte, a run header and a row marker are each taken alone;
// the pixel word of a literal appears in the output register the next cycle.
// A run value byte with count N that fits its row holds the input while N
// pixel words come from the run counter, one per cycle unless the output
// stalls; a run of zero gives none. A run that overflows its row holds the
// input for one pixel word per pixel left in the row, then the error word.
// An output stall holds intake and run emission (single output register).
// Frame start clears the scan counters; after the last pixel or an error,
// bytes are dropped until the next frame start. The user must write
// configuration only while the block is idle; the block does not enforce it.
module rle_bitmap_rotating_decoder
    import rbrd_pkg::*;
#(
    parameter int SIDE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data,
    rbrd_in_if.sink           i_in,
    rbrd_out_if.source        o_out
);

    t_cmd cmd;
    t_sts sts;

    // Sequencing of intake, run emission and error word.
    rbrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Counters, placement and output register.
    rbrd_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_frame_start   (i_in.frame_start),
        .i_data_byte     (i_in.data_byte),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_pixel_address (o_out.pixel_address),
        .o_pixel_value   (o_out.pixel_value),
        .o_write_enable  (o_out.write_enable),
        .o_last_of_run   (o_out.last_of_run),
        .o_frame_done    (o_out.frame_done),
        .o_error         (o_out.error)
    );

endmodule
